// ===== rtl/core/kce_pkg.sv =====
// ----------------------------------------------------------------------------
// kce_pkg: shared types and helpers for the keypad code entry core
// Word layouts, register indexes, controller states and commands, and the
// cursor grid stepping function.
// ----------------------------------------------------------------------------
package kce_pkg;

   localparam int CODE_DIGITS_DEF = 8;
   localparam int ADDR_W          = 4;
   localparam int DIV_STEPS       = 17;   // quotient bits of accum / interval
   localparam int STEP_MOD        = 12;   // cursor path period

   localparam logic [3:0]  NO_CELL   = 4'd15;
   localparam logic [16:0] ACCUM_MAX = '1;
   localparam logic [23:0] TIME_MAX  = '1;

   localparam int KEY_A    = 4;
   localparam int KEY_B    = 5;
   localparam int KEY_X    = 6;
   localparam int KEY_Y    = 7;
   localparam int KEY_PLUS = 8;

   typedef enum logic [1:0] {
      REG_DELAY,
      REG_INTERVAL,
      REG_TIMEOUT,
      REG_ENABLE
   } reg_index_type;

   typedef struct packed {
      logic        req_type;
      logic [8:0]  pressed_now;
      logic [8:0]  held_now;
      logic [15:0] delta_ms;
   } req_word_type;

   typedef struct packed {
      logic        consumed;
      logic [3:0]  cursor_digit;
      logic [3:0]  code_length;
      logic [31:0] code_digits;
      logic        ready_to_submit;
      logic        locked_out;
   } rsp_word_type;

   typedef struct packed {
      logic [15:0] repeat_delay_ms;
      logic [15:0] repeat_interval_ms;
      logic [23:0] lock_limit_ms;
      logic        timeout_enable;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_ACCUM,
      ST_DELAY,
      ST_DIV_INIT,
      ST_DIV,
      ST_STEP,
      ST_TICK_ADD,
      ST_TICK_CMP,
      ST_RESP
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_APPLY,
      OP_ACCUM,
      OP_DELAY,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_STEP,
      OP_TICK_ADD,
      OP_TICK_CMP,
      OP_RESULT
   } op_type;

   typedef enum logic [1:0] {
      KIND_SIMPLE,
      KIND_TICK,
      KIND_REPEAT
   } kind_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     accum_short;
      logic     repeat_active;
      logic     div_last;
      logic     steps_zero;
      logic     out_free;
   } stat_type;

   function automatic logic one_hot4(input logic [3:0] v);
      return (v != 4'd0) && ((v & (v - 4'd1)) == 4'd0);
   endfunction

   // Digit at a grid cell; the two empty cells read NO_CELL.
   function automatic logic [3:0] cell_at(input logic [1:0] row, input logic [1:0] col);
      logic [3:0] c;
      case ({row, col})
         4'b00_00: c = 4'd1;
         4'b00_01: c = 4'd2;
         4'b00_10: c = 4'd3;
         4'b01_00: c = 4'd4;
         4'b01_01: c = 4'd5;
         4'b01_10: c = 4'd6;
         4'b10_00: c = 4'd7;
         4'b10_01: c = 4'd8;
         4'b10_10: c = 4'd9;
         4'b11_01: c = 4'd0;
         default:  c = NO_CELL;
      endcase
      return c;
   endfunction

   // One cursor move with wrap; at most two empty cells are skipped.
   function automatic logic [3:0] step_cursor(input logic [3:0] pos, input logic [3:0] dir);
      logic [1:0] row;
      logic [1:0] col;
      logic [1:0] drow;
      logic [1:0] dcol;
      logic [2:0] csum;
      logic [3:0] hit;
      logic [3:0] res;
      logic       found;
      drow  = 2'd0;
      dcol  = 2'd0;
      res   = pos;
      found = 1'b0;
      case (pos)
         4'd1: begin row = 2'd0; col = 2'd0; end
         4'd2: begin row = 2'd0; col = 2'd1; end
         4'd3: begin row = 2'd0; col = 2'd2; end
         4'd4: begin row = 2'd1; col = 2'd0; end
         4'd5: begin row = 2'd1; col = 2'd1; end
         4'd6: begin row = 2'd1; col = 2'd2; end
         4'd7: begin row = 2'd2; col = 2'd0; end
         4'd8: begin row = 2'd2; col = 2'd1; end
         4'd9: begin row = 2'd2; col = 2'd2; end
         default: begin row = 2'd3; col = 2'd1; end
      endcase
      case (dir)
         4'b0001: drow = 2'd3;
         4'b0010: drow = 2'd1;
         4'b0100: dcol = 2'd2;
         4'b1000: dcol = 2'd1;
         default: found = 1'b1;
      endcase
      for (int k = 0; k < 3; k++) begin
         if (!found) begin
            csum = {1'b0, col} + {1'b0, dcol};
            if (csum >= 3'd3) begin
               csum = csum - 3'd3;
            end
            col  = csum[1:0];
            row  = row + drow;
            hit  = cell_at(row, col);
            if (hit != NO_CELL) begin
               res   = hit;
               found = 1'b1;
            end
         end
      end
      return res;
   endfunction

endpackage

// ===== rtl/core/kce_csr.sv =====
// ----------------------------------------------------------------------------
// kce_csr: configuration registers
// APB-style register file for repeat timing and the entry timeout.
// ----------------------------------------------------------------------------
module kce_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [kce_pkg::ADDR_W-1:0]  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready,
   output kce_pkg::cfg_type            cfg
);
   import kce_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type idx;
   logic          wr_en;

   assign idx    = reg_index_type'(paddr[3:2]);
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_DELAY:    cfg_in.repeat_delay_ms    = pwdata[15:0];
            REG_INTERVAL: cfg_in.repeat_interval_ms = pwdata[15:0];
            REG_TIMEOUT:  cfg_in.lock_limit_ms      = pwdata[23:0];
            REG_ENABLE:   cfg_in.timeout_enable     = pwdata[0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_DELAY:    prdata = 32'(cfg_ff.repeat_delay_ms);
         REG_INTERVAL: prdata = 32'(cfg_ff.repeat_interval_ms);
         REG_TIMEOUT:  prdata = 32'(cfg_ff.lock_limit_ms);
         REG_ENABLE:   prdata = 32'(cfg_ff.timeout_enable);
         default:      prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.repeat_delay_ms    <= 16'd400;
         cfg_ff.repeat_interval_ms <= 16'd100;
         cfg_ff.lock_limit_ms      <= 24'd60000;
         cfg_ff.timeout_enable     <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/core/kce_ctrl.sv =====
// ----------------------------------------------------------------------------
// kce_ctrl: sequencing state machine
// Walks one word through decode, repeat timing, division, cursor stepping
// or tick accounting, then hands the result to the output register.
// ----------------------------------------------------------------------------
module kce_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  kce_pkg::stat_type stat,
   output kce_pkg::cmd_type  cmd
);
   import kce_pkg::*;

   state_type state_ff;
   state_type state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            case (stat.kind)
               KIND_TICK:   state_in = ST_TICK_ADD;
               KIND_REPEAT: state_in = ST_ACCUM;
               default:     state_in = ST_RESP;
            endcase
         end
         ST_ACCUM:    state_in = ST_DELAY;
         ST_DELAY: begin
            if (!stat.repeat_active && stat.accum_short) state_in = ST_RESP;
            else state_in = ST_DIV_INIT;
         end
         ST_DIV_INIT: state_in = ST_DIV;
         ST_DIV: begin
            if (stat.div_last) state_in = ST_STEP;
         end
         ST_STEP: begin
            if (stat.steps_zero) state_in = ST_RESP;
         end
         ST_TICK_ADD: state_in = ST_TICK_CMP;
         ST_TICK_CMP: state_in = ST_RESP;
         ST_RESP: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      cmd.op    = OP_NONE;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = OP_LOAD;
         end
         ST_DECODE:   cmd.op = OP_APPLY;
         ST_ACCUM:    cmd.op = OP_ACCUM;
         ST_DELAY: begin
            if (!stat.repeat_active && !stat.accum_short) cmd.op = OP_DELAY;
         end
         ST_DIV_INIT: cmd.op = OP_DIV_INIT;
         ST_DIV:      cmd.op = OP_DIV_STEP;
         ST_STEP: begin
            if (!stat.steps_zero) cmd.op = OP_STEP;
         end
         ST_TICK_ADD: cmd.op = OP_TICK_ADD;
         ST_TICK_CMP: cmd.op = OP_TICK_CMP;
         ST_RESP: begin
            if (stat.out_free) cmd.op = OP_RESULT;
         end
         default:     cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/kce_dpath.sv =====
// ----------------------------------------------------------------------------
// kce_dpath: entry datapath
// Input word latch, cursor, digit store, repeat accumulator with a
// one-bit-per-cycle divider, timeout counter and output register.
// ----------------------------------------------------------------------------
module kce_dpath #(
   parameter int CODE_DIGITS = kce_pkg::CODE_DIGITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  kce_pkg::req_word_type req_word,
   input  kce_pkg::cfg_type      cfg,
   input  kce_pkg::cmd_type      cmd,
   output kce_pkg::stat_type     stat,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output kce_pkg::rsp_word_type rsp_word
);
   import kce_pkg::*;

   localparam int CNT_W     = $clog2(CODE_DIGITS + 1);
   localparam int IDX_W     = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);
   localparam int SHOWN     = (CODE_DIGITS < 8) ? CODE_DIGITS : 8;

   // control state
   logic [3:0]           cursor_ff, cursor_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [3:0]           dir_ff, dir_in;
   logic [16:0]          accum_ff, accum_in;
   logic                 active_ff, active_in;
   logic [23:0]          total_ff, total_in;
   logic                 expired_ff, expired_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [3:0]           steps_ff, steps_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // payload
   req_word_type         in_ff;
   logic [3:0]           store_ff [CODE_DIGITS];
   logic                 consumed_ff, consumed_in;
   logic [16:0]          dvd_ff, dvd_in;
   logic [15:0]          rem_ff, rem_in;
   logic [3:0]           q12_ff, q12_in;
   rsp_word_type         rsp_word_ff;
   rsp_word_type         rsp_word_in;

   logic [3:0]  down, hold;
   logic        conflict;
   logic        is_tick;
   logic        tick_live;
   logic        store_we;
   kind_type    kind_sel;
   logic [15:0] ivl;
   logic [16:0] div_t, div_sub;
   logic        div_ge;
   logic [15:0] rem_nx;
   logic [4:0]  q2;
   logic [3:0]  q_nx;
   logic [17:0] accum_sum;
   logic [24:0] total_sum;
   logic [31:0] packed_digits;

   assign down     = in_ff.pressed_now[3:0];
   assign hold     = in_ff.held_now[3:0];
   assign is_tick  = in_ff.req_type;
   assign conflict = ((down != 4'd0) && !one_hot4(down)) ||
                     ((hold != 4'd0) && !one_hot4(hold)) ||
                     ((down != 4'd0) && (hold != 4'd0) && (down != hold));
   assign tick_live = !expired_ff && (in_ff.delta_ms != 16'd0) && cfg.timeout_enable;

   always_comb begin
      if (is_tick) begin
         kind_sel = tick_live ? KIND_TICK : KIND_SIMPLE;
      end else if (!expired_ff && ((down | hold) != 4'd0) && !conflict &&
                   (down == 4'd0) && (dir_ff == hold)) begin
         kind_sel = KIND_REPEAT;
      end else begin
         kind_sel = KIND_SIMPLE;
      end
   end

   assign stat.kind          = kind_sel;
   assign stat.accum_short   = accum_ff < {1'b0, cfg.repeat_delay_ms};
   assign stat.repeat_active = active_ff;
   assign stat.div_last      = div_cnt_ff == DIV_CNT_W'(1);
   assign stat.steps_zero    = steps_ff == 4'd0;
   assign stat.out_free      = !rsp_valid_ff || rsp_ready;

   // restoring divider step, quotient kept mod 12
   assign ivl     = (cfg.repeat_interval_ms == 16'd0) ? 16'd1 : cfg.repeat_interval_ms;
   assign div_t   = {rem_ff, dvd_ff[16]};
   assign div_ge  = div_t >= {1'b0, ivl};
   assign div_sub = div_t - {1'b0, ivl};
   assign rem_nx  = div_ge ? div_sub[15:0] : div_t[15:0];
   assign q2      = {q12_ff, 1'b0} + 5'(div_ge);
   assign q_nx    = (q2 >= 5'(STEP_MOD)) ? 4'(q2 - 5'(STEP_MOD)) : q2[3:0];

   assign accum_sum = {1'b0, accum_ff} + {2'b0, in_ff.delta_ms};
   assign total_sum = {1'b0, total_ff} + {9'd0, in_ff.delta_ms};

   always_comb begin
      cursor_in    = cursor_ff;
      count_in     = count_ff;
      dir_in       = dir_ff;
      accum_in     = accum_ff;
      active_in    = active_ff;
      total_in     = total_ff;
      expired_in   = expired_ff;
      div_cnt_in   = div_cnt_ff;
      steps_in     = steps_ff;
      consumed_in  = consumed_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      q12_in       = q12_ff;
      store_we     = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      case (cmd.op)
         OP_APPLY: begin
            if (is_tick || expired_ff) begin
               consumed_in = 1'b0;
            end else if (down == 4'd0 && hold == 4'd0) begin
               dir_in    = 4'd0;
               accum_in  = 17'd0;
               active_in = 1'b0;
               consumed_in = |in_ff.pressed_now[KEY_PLUS:KEY_A];
               if (in_ff.pressed_now[KEY_X]) begin
                  if (count_ff != CNT_W'(0)) count_in = count_ff - CNT_W'(1);
               end else if (in_ff.pressed_now[KEY_Y]) begin
                  count_in = CNT_W'(0);
               end else if (in_ff.pressed_now[KEY_A]) begin
                  if (count_ff < CNT_W'(CODE_DIGITS)) begin
                     store_we = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end
               end
            end else begin
               consumed_in = 1'b1;
               if (conflict) begin
                  dir_in    = 4'd0;
                  accum_in  = 17'd0;
                  active_in = 1'b0;
               end else if (down != 4'd0) begin
                  cursor_in = step_cursor(cursor_ff, down);
                  dir_in    = down;
                  accum_in  = 17'd0;
                  active_in = 1'b0;
               end else if (dir_ff != hold) begin
                  dir_in    = hold;
                  accum_in  = 17'd0;
                  active_in = 1'b0;
               end
            end
         end
         OP_ACCUM: begin
            accum_in = accum_sum[17] ? ACCUM_MAX : accum_sum[16:0];
         end
         OP_DELAY: begin
            accum_in  = accum_ff - {1'b0, cfg.repeat_delay_ms};
            active_in = 1'b1;
            cursor_in = step_cursor(cursor_ff, dir_ff);
         end
         OP_DIV_INIT: begin
            dvd_in     = accum_ff;
            rem_in     = 16'd0;
            q12_in     = 4'd0;
            div_cnt_in = DIV_CNT_W'(DIV_STEPS);
         end
         OP_DIV_STEP: begin
            dvd_in     = {dvd_ff[15:0], 1'b0};
            rem_in     = rem_nx;
            q12_in     = q_nx;
            div_cnt_in = div_cnt_ff - DIV_CNT_W'(1);
            if (stat.div_last) begin
               accum_in = {1'b0, rem_nx};
               steps_in = q_nx;
            end
         end
         OP_STEP: begin
            cursor_in = step_cursor(cursor_ff, dir_ff);
            steps_in  = steps_ff - 4'd1;
         end
         OP_TICK_ADD: begin
            total_in = total_sum[24] ? TIME_MAX : total_sum[23:0];
         end
         OP_TICK_CMP: begin
            if (total_ff >= cfg.lock_limit_ms) expired_in = 1'b1;
         end
         OP_RESULT: begin
            rsp_valid_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // only the first eight digits are shown; nibbles past the count read zero
   always_comb begin
      packed_digits = 32'd0;
      for (int i = 0; i < SHOWN; i++) begin
         if (CNT_W'(i) < count_ff) packed_digits[4*i +: 4] = store_ff[i];
      end
   end

   always_comb begin
      rsp_word_in.consumed        = consumed_ff;
      rsp_word_in.cursor_digit    = cursor_ff;
      rsp_word_in.code_length     = 4'(count_ff);
      rsp_word_in.code_digits     = packed_digits;
      rsp_word_in.ready_to_submit = !expired_ff && (count_ff == CNT_W'(CODE_DIGITS));
      rsp_word_in.locked_out      = expired_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff    <= 4'd1;
         count_ff     <= CNT_W'(0);
         dir_ff       <= 4'd0;
         accum_ff     <= 17'd0;
         active_ff    <= 1'b0;
         total_ff     <= 24'd0;
         expired_ff   <= 1'b0;
         div_cnt_ff   <= DIV_CNT_W'(0);
         steps_ff     <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cursor_ff    <= cursor_in;
         count_ff     <= count_in;
         dir_ff       <= dir_in;
         accum_ff     <= accum_in;
         active_ff    <= active_in;
         total_ff     <= total_in;
         expired_ff   <= expired_in;
         div_cnt_ff   <= div_cnt_in;
         steps_ff     <= steps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD) in_ff <= req_word;
      if (store_we) store_ff[count_ff[IDX_W-1:0]] <= cursor_ff;
      if (cmd.op == OP_RESULT) rsp_word_ff <= rsp_word_in;
      consumed_ff <= consumed_in;
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      q12_ff      <= q12_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// ===== rtl/core/keypad_code_entry_with_repeat_core.sv =====
// ----------------------------------------------------------------------------
// keypad_code_entry_with_repeat_core: D-pad driven numeric code entry
// Flow: a plain button word goes from decode to the response; a tick adds
//   its delta and checks the timeout; a held-direction repeat word, once the
//   delay is reached, divides the repeat accumulator by the interval, then
//   makes up to 11 cursor steps. A new word is taken only when the sequencer
//   is idle, also while the last result still sits in the output register.
// Reset (synchronous, active high): cursor on 1, empty code, no repeat,
//   timeout clear, registers 400 / 100 / 60000 / disabled.
// ----------------------------------------------------------------------------
module keypad_code_entry_with_repeat_core #(
   parameter int CODE_DIGITS = kce_pkg::CODE_DIGITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_ready,
   input  kce_pkg::req_word_type       req_word,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output kce_pkg::rsp_word_type       rsp_word,
   // register port
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [kce_pkg::ADDR_W-1:0]  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);
   import kce_pkg::*;

   cfg_type  cfg;
   cmd_type  cmd;
   stat_type stat;

   // Register file: repeat delay, repeat interval, timeout, timeout enable.
   kce_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Controller: one word at a time; ready only when the sequencer is idle.
   kce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath: the entry state registers and the output register live here.
   kce_dpath #(
      .CODE_DIGITS (CODE_DIGITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cfg       (cfg),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   // Sequencer is busy right after taking a word.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("req_ready high the cycle after an accept");

   // Cursor always sits on a real digit.
   a_cursor_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.cursor_digit <= 4'd9))
      else $error("cursor off the digit grid");

   // Locked entry never reports a submittable code.
   a_lock_vs_submit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.locked_out) |-> !rsp_word.ready_to_submit)
      else $error("ready_to_submit while locked out");

   // Reported length never passes the code size.
   a_length_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_word.code_length} <= 5'(CODE_DIGITS)))
      else $error("code_length beyond code size");

endmodule
